// ===== rtl/core/aobt_pkg.sv =====
package aobt_pkg;

    localparam logic [63:0] ONE_Q32    = 64'h0000_0001_0000_0000;
    localparam logic [63:0] HALF_Q32   = 64'h0000_0000_8000_0000;
    localparam logic [63:0] MAX_U64    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LN2_Q32    = 64'd2977044472;
    localparam logic [63:0] LOG2E_Q32  = 64'd6196328019;
    localparam logic [63:0] EXP_LIMIT  = 64'h0000_0040_0000_0000;
    localparam logic [63:0] ROOT_BIT0  = 64'h4000_0000_0000_0000;
    localparam logic [7:0]  DEFAULT_STEPS = 8'd100;
    localparam logic [3:0]  TAYLOR_TERMS  = 4'd12;
    localparam logic [5:0]  ROOT_LAST     = 6'd31;
    localparam logic [5:0]  FDIV_LAST     = 6'd31;
    localparam logic [6:0]  DIV_FULL_ITER  = 7'd64;
    localparam logic [6:0]  DIV_SHORT_ITER = 7'd34;
    localparam int          DIV_SHORT_SHIFT = 30;

    typedef logic [63:0] q32_t;

    function automatic q32_t payoff(input logic put, input q32_t px, input q32_t k);
        q32_t r;
        r = '0;
        if (put)
        begin
            if (k > px)
            begin
                r = k - px;
            end
        end
        else
        begin
            if (px > k)
            begin
                r = px - k;
            end
        end
        return r;
    endfunction

    function automatic q32_t add_sat(input q32_t a, input q32_t b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? MAX_U64 : s[63:0];
    endfunction

endpackage

// ===== rtl/core/aobt_mul.sv =====
module aobt_mul
    import aobt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         go,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [1:0]   cnt_reg;
    logic         run_reg;
    logic         done_reg;
    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    always_comb
    begin
        pa = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        pb = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp = {32'b0, pa} * {32'b0, pb};
        pp_sh = {64'b0, pp} << (7'(cnt_reg[1]) * 7'd32 + 7'(cnt_reg[0]) * 7'd32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == 2'd3);
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/core/aobt_div.sv =====
module aobt_div
    import aobt_pkg::*;
#(
    parameter int DEN_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [63:0]      num,
    input  logic [DEN_W-1:0] den,
    input  logic             short_mode,
    output logic             done,
    output logic [63:0]      quo
);

    logic [63:0]      sh_reg;
    logic [63:0]      q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [6:0]       cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fit;

    always_comb
    begin
        trial = {rem_reg, sh_reg[63]};
        fit   = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == 7'd1);
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= short_mode ? DIV_SHORT_ITER : DIV_FULL_ITER;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            sh_reg  <= short_mode ? (num << DIV_SHORT_SHIFT) : num;
            q_reg   <= '0;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            sh_reg <= sh_reg << 1;
            q_reg  <= {q_reg[62:0], fit};
            if (fit)
            begin
                rem_reg <= DEN_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= DEN_W'(trial);
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ===== rtl/core/american_option_binomial_tree.sv =====
// A request with zero expiry, spot, strike or volatility gives its price in the cycle after the request.
// Otherwise the run time for N steps is set by the shared 64x64 multiplier and the
// bit-serial divider used by each exp evaluation.
// Throughput: one request at a time; busy stays high until the price strobe.
// Reset: asynchronous active-low; clears control and sets num_steps to 100.
module american_option_binomial_tree
    import aobt_pkg::*;
#(
    parameter int MAX_STEPS = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [31:0] spot,
    input  logic [31:0] strike,
    input  logic [31:0] expiry,
    input  logic signed [31:0] rate,
    input  logic signed [31:0] dividend_yield,
    input  logic [31:0] volatility,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output logic [31:0] price,
    output logic        price_valid
);

    localparam int NW  = $clog2(MAX_STEPS + 1);
    localparam int PAW = $clog2(2 * MAX_STEPS + 1);
    localparam int DW  = (NW > 4) ? NW : 4;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DT     = 5'd1;
    localparam logic [4:0] S_SQRT   = 5'd2;
    localparam logic [4:0] S_A      = 5'd3;
    localparam logic [4:0] S_RM     = 5'd4;
    localparam logic [4:0] S_RD     = 5'd5;
    localparam logic [4:0] S_DM     = 5'd6;
    localparam logic [4:0] S_DD     = 5'd7;
    localparam logic [4:0] S_SETUP  = 5'd8;
    localparam logic [4:0] S_SETUPW = 5'd9;
    localparam logic [4:0] S_PSEL   = 5'd10;
    localparam logic [4:0] S_FDIV   = 5'd11;
    localparam logic [4:0] S_NA     = 5'd12;
    localparam logic [4:0] S_TBL    = 5'd13;
    localparam logic [4:0] S_TBLW   = 5'd14;
    localparam logic [4:0] S_LRD    = 5'd15;
    localparam logic [4:0] S_LWR    = 5'd16;
    localparam logic [4:0] S_BINIT  = 5'd17;
    localparam logic [4:0] S_BINIT2 = 5'd18;
    localparam logic [4:0] S_BRD    = 5'd19;
    localparam logic [4:0] S_BM1    = 5'd20;
    localparam logic [4:0] S_BM2    = 5'd21;
    localparam logic [4:0] S_BM3    = 5'd22;
    localparam logic [4:0] S_FIN    = 5'd23;
    localparam logic [4:0] S_FIN2   = 5'd24;
    localparam logic [4:0] S_E0     = 5'd25;
    localparam logic [4:0] S_EY     = 5'd26;
    localparam logic [4:0] S_ETM    = 5'd27;
    localparam logic [4:0] S_ETD    = 5'd28;
    localparam logic [4:0] S_EPR    = 5'd29;

    logic [4:0]  state_reg, state_next;
    logic [4:0]  ret_reg, ret_next;
    logic        wait_reg, wait_next;
    logic        valid_reg, valid_next;
    logic [31:0] price_reg, price_next;
    logic [7:0]  num_steps_reg;

    logic        put_reg, put_next;
    logic [31:0] spot_reg, spot_next;
    logic [31:0] strike_reg, strike_next;
    logic [31:0] expiry_reg, expiry_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] divy_reg, divy_next;
    logic [31:0] vol_reg, vol_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] i_reg, i_next;
    logic [NW-1:0] t_reg, t_next;
    logic [PAW-1:0] j_reg, j_next;
    logic [1:0]  sk_reg, sk_next;
    logic [5:0]  cnt_reg, cnt_next;

    q32_t root_x_reg, root_x_next;
    q32_t root_res_reg, root_res_next;
    q32_t root_bit_reg, root_bit_next;
    q32_t rem_reg, rem_next;
    q32_t den_reg, den_next;
    logic [31:0] quo_reg, quo_next;
    q32_t a_reg, a_next;
    q32_t tmp_reg, tmp_next;
    q32_t rdt_reg, rdt_next;
    q32_t gdt_reg, gdt_next;
    q32_t disc_reg, disc_next;
    q32_t growth_reg, growth_next;
    q32_t up_reg, up_next;
    q32_t dn_reg, dn_next;
    q32_t p_reg, p_next;
    q32_t x_reg, x_next;
    q32_t lo_reg, lo_next;
    q32_t c1_reg, c1_next;
    q32_t ex_m_reg, ex_m_next;
    q32_t ex_x_reg, ex_x_next;
    logic ex_neg_reg, ex_neg_next;
    logic [7:0] ex_e_reg, ex_e_next;
    logic [31:0] ex_f_reg, ex_f_next;
    logic [31:0] ex_z_reg, ex_z_next;
    q32_t ex_sum_reg, ex_sum_next;
    q32_t ex_term_reg, ex_term_next;
    logic [3:0] ex_k_reg, ex_k_next;
    q32_t ex_res_reg, ex_res_next;

    logic         mul_go;
    q32_t         mul_a;
    q32_t         mul_b;
    logic         mul_done;
    logic [127:0] mul_prod;
    q32_t         mul_satv;
    logic         div_go;
    q32_t         div_num;
    logic [DW-1:0] div_den;
    logic         div_short;
    logic         div_done;
    q32_t         div_quo;

    q32_t price_mem [2*MAX_STEPS+1];
    q32_t value_mem [MAX_STEPS+1];
    logic           pm_we, pm_re;
    logic [PAW-1:0] pm_waddr, pm_raddr;
    q32_t           pm_wdata, pm_q;
    logic           vm_we, vm_re;
    logic [NW-1:0]  vm_waddr, vm_raddr;
    q32_t           vm_wdata, vm_q;

    q32_t s_q;
    q32_t k_q;
    q32_t ex_mag;
    q32_t root_try;
    q32_t fdiv_dr;
    q32_t ex_shift;
    logic [127:0] ex_wide;
    logic [31:0] rate_mag;
    logic [31:0] divy_mag;
    logic [PAW-1:0] b_pidx;
    q32_t cont;
    q32_t exer;

    aobt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    aobt_div #(
        .DEN_W (DW)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (div_go),
        .num        (div_num),
        .den        (div_den),
        .short_mode (div_short),
        .done       (div_done),
        .quo        (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            price_mem[pm_waddr] <= pm_wdata;
        end
        if (pm_re)
        begin
            pm_q <= price_mem[pm_raddr];
        end
        if (vm_we)
        begin
            value_mem[vm_waddr] <= vm_wdata;
        end
        if (vm_re)
        begin
            vm_q <= value_mem[vm_raddr];
        end
    end

    always_comb
    begin
        mul_satv = (mul_prod[127:96] != 32'd0) ? MAX_U64 : mul_prod[95:32];
        s_q      = {16'b0, spot_reg, 16'b0};
        k_q      = {16'b0, strike_reg, 16'b0};
        ex_mag   = ex_x_reg[63] ? (64'd0 - ex_x_reg) : ex_x_reg;
        root_try = root_res_reg + root_bit_reg;
        fdiv_dr  = den_reg - rem_reg;
        rate_mag = rate_reg[31] ? (32'd0 - rate_reg) : rate_reg;
        divy_mag = divy_reg[31] ? (32'd0 - divy_reg) : divy_reg;
        b_pidx   = (PAW'(i_reg) << 1) + PAW'(n_reg) - PAW'(t_reg);
        ex_wide  = {64'b0, mul_satv} << ex_e_reg[5:0];
        if (!ex_neg_reg)
        begin
            if (ex_e_reg >= 8'd64 || ex_wide[127:64] != 64'd0)
            begin
                ex_shift = MAX_U64;
            end
            else
            begin
                ex_shift = ex_wide[63:0];
            end
        end
        else
        begin
            ex_shift = (ex_e_reg >= 8'd64) ? 64'd0 : (mul_satv >> ex_e_reg[5:0]);
        end
        cont = mul_satv;
        exer = payoff(put_reg, pm_q, k_q);
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        wait_next     = wait_reg;
        valid_next    = 1'b0;
        price_next    = price_reg;
        put_next      = put_reg;
        spot_next     = spot_reg;
        strike_next   = strike_reg;
        expiry_next   = expiry_reg;
        rate_next     = rate_reg;
        divy_next     = divy_reg;
        vol_next      = vol_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        t_next        = t_reg;
        j_next        = j_reg;
        sk_next       = sk_reg;
        cnt_next      = cnt_reg;
        root_x_next   = root_x_reg;
        root_res_next = root_res_reg;
        root_bit_next = root_bit_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        quo_next      = quo_reg;
        a_next        = a_reg;
        tmp_next      = tmp_reg;
        rdt_next      = rdt_reg;
        gdt_next      = gdt_reg;
        disc_next     = disc_reg;
        growth_next   = growth_reg;
        up_next       = up_reg;
        dn_next       = dn_reg;
        p_next        = p_reg;
        x_next        = x_reg;
        lo_next       = lo_reg;
        c1_next       = c1_reg;
        ex_m_next     = ex_m_reg;
        ex_x_next     = ex_x_reg;
        ex_neg_next   = ex_neg_reg;
        ex_e_next     = ex_e_reg;
        ex_f_next     = ex_f_reg;
        ex_z_next     = ex_z_reg;
        ex_sum_next   = ex_sum_reg;
        ex_term_next  = ex_term_reg;
        ex_k_next     = ex_k_reg;
        ex_res_next   = ex_res_reg;
        mul_go    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_go    = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_short = 1'b0;
        pm_we     = 1'b0;
        pm_waddr  = '0;
        pm_wdata  = '0;
        pm_re     = 1'b0;
        pm_raddr  = '0;
        vm_we     = 1'b0;
        vm_waddr  = '0;
        vm_wdata  = '0;
        vm_re     = 1'b0;
        vm_raddr  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    put_next    = action;
                    spot_next   = spot;
                    strike_next = strike;
                    expiry_next = expiry;
                    rate_next   = rate;
                    divy_next   = dividend_yield;
                    vol_next    = volatility;
                    wait_next   = 1'b0;
                    if (expiry == 32'd0 || spot == 32'd0 || strike == 32'd0
                        || volatility == 32'd0)
                    begin
                        price_next = 32'(payoff(action, {32'b0, spot}, {32'b0, strike}));
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        if (num_steps_reg == 8'd0)
                        begin
                            n_next = NW'(1);
                        end
                        else if (32'(num_steps_reg) > 32'(MAX_STEPS))
                        begin
                            n_next = NW'(MAX_STEPS);
                        end
                        else
                        begin
                            n_next = NW'(num_steps_reg);
                        end
                        state_next = S_DT;
                    end
                end
            end
            S_DT:
            begin
                div_num = {32'b0, expiry_reg} << 24;
                div_den = DW'(n_reg);
                if (!wait_reg)
                begin
                    div_go    = 1'b1;
                    wait_next = 1'b1;
                end
                else if (div_done)
                begin
                    wait_next     = 1'b0;
                    root_x_next   = div_quo;
                    root_res_next = '0;
                    root_bit_next = ROOT_BIT0;
                    cnt_next      = '0;
                    state_next    = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (root_x_reg >= root_try)
                begin
                    root_x_next   = root_x_reg - root_try;
                    root_res_next = (root_res_reg >> 1) + root_bit_reg;
                end
                else
                begin
                    root_res_next = root_res_reg >> 1;
                end
                root_bit_next = root_bit_reg >> 2;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == ROOT_LAST)
                begin
                    state_next = S_A;
                end
            end
            S_A:
            begin
                mul_a = {32'b0, vol_reg};
                mul_b = root_res_reg;
                if (!wait_reg)
                begin
                    mul_go    = 1'b1;
                    wait_next = 1'b1;
                end
                else if (mul_done)
                begin
                    wait_next  = 1'b0;
                    a_next     = {20'b0, mul_prod[63:20]};
                    state_next = S_RM;
                end
            end
            S_RM, S_DM:
            begin
                mul_a = {32'b0, (state_reg == S_RM) ? rate_mag : divy_mag};
                mul_b = {32'b0, expiry_reg};
                if (!wait_reg)
                begin
                    mul_go    = 1'b1;
                    wait_next = 1'b1;
                end
                else if (mul_done)
                begin
                    wait_next  = 1'b0;
                    tmp_next   = mul_prod[63:0];
                    state_next = (state_reg == S_RM) ? S_RD : S_DD;
                end
            end
            S_RD, S_DD:
            begin
                div_num = tmp_reg;
                div_den = DW'(n_reg);
                if (!wait_reg)
                begin
                    div_go    = 1'b1;
                    wait_next = 1'b1;
                end
                else if (div_done)
                begin
                    wait_next = 1'b0;
                    if (state_reg == S_RD)
                    begin
                        rdt_next   = rate_reg[31] ? (64'd0 - (div_quo >> 20))
                                                  : (div_quo >> 20);
                        state_next = S_DM;
                    end
                    else
                    begin
                        gdt_next   = divy_reg[31] ? (rdt_reg + (div_quo >> 20))
                                                  : (rdt_reg - (div_quo >> 20));
                        sk_next    = 2'd0;
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                ex_m_next = ONE_Q32;
                case (sk_reg)
                    2'd0:    ex_x_next = 64'd0 - rdt_reg;
                    2'd1:    ex_x_next = gdt_reg;
                    2'd2:    ex_x_next = a_reg;
                    default: ex_x_next = 64'd0 - a_reg;
                endcase
                ret_next   = S_SETUPW;
                wait_next  = 1'b0;
                state_next = S_E0;
            end
            S_SETUPW:
            begin
                case (sk_reg)
                    2'd0:    disc_next   = ex_res_reg;
                    2'd1:    growth_next = ex_res_reg;
                    2'd2:    up_next     = ex_res_reg;
                    default: dn_next     = ex_res_reg;
                endcase
                sk_next    = sk_reg + 2'd1;
                state_next = (sk_reg == 2'd3) ? S_PSEL : S_SETUP;
            end
            S_PSEL:
            begin
                if (up_reg <= dn_reg)
                begin
                    p_next     = HALF_Q32;
                    state_next = S_NA;
                end
                else if (growth_reg <= dn_reg)
                begin
                    p_next     = '0;
                    state_next = S_NA;
                end
                else if (growth_reg >= up_reg)
                begin
                    p_next     = ONE_Q32;
                    state_next = S_NA;
                end
                else
                begin
                    rem_next   = growth_reg - dn_reg;
                    den_next   = up_reg - dn_reg;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = S_FDIV;
                end
            end
            S_FDIV:
            begin
                if (rem_reg >= fdiv_dr)
                begin
                    rem_next = rem_reg - fdiv_dr;
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_reg << 1;
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == FDIV_LAST)
                begin
                    p_next     = {32'b0, quo_next};
                    state_next = S_NA;
                end
            end
            S_NA:
            begin
                mul_a = a_reg;
                mul_b = 64'(n_reg);
                if (!wait_reg)
                begin
                    mul_go    = 1'b1;
                    wait_next = 1'b1;
                end
                else if (mul_done)
                begin
                    wait_next  = 1'b0;
                    x_next     = 64'd0 - mul_prod[63:0];
                    j_next     = '0;
                    state_next = S_TBL;
                end
            end
            S_TBL:
            begin
                ex_m_next  = s_q;
                ex_x_next  = x_reg;
                ret_next   = S_TBLW;
                wait_next  = 1'b0;
                state_next = S_E0;
            end
            S_TBLW:
            begin
                pm_we    = 1'b1;
                pm_waddr = j_reg;
                pm_wdata = ex_res_reg;
                x_next   = x_reg + a_reg;
                if (j_reg == (PAW'(n_reg) << 1))
                begin
                    i_next     = '0;
                    state_next = S_LRD;
                end
                else
                begin
                    j_next     = j_reg + PAW'(1);
                    state_next = S_TBL;
                end
            end
            S_LRD:
            begin
                pm_re      = 1'b1;
                pm_raddr   = PAW'(i_reg) << 1;
                state_next = S_LWR;
            end
            S_LWR:
            begin
                vm_we    = 1'b1;
                vm_waddr = i_reg;
                vm_wdata = exer;
                if (i_reg == n_reg)
                begin
                    t_next     = n_reg - NW'(1);
                    state_next = S_BINIT;
                end
                else
                begin
                    i_next     = i_reg + NW'(1);
                    state_next = S_LRD;
                end
            end
            S_BINIT:
            begin
                vm_re      = 1'b1;
                vm_raddr   = '0;
                i_next     = '0;
                state_next = S_BINIT2;
            end
            S_BINIT2:
            begin
                lo_next    = vm_q;
                state_next = S_BRD;
            end
            S_BRD:
            begin
                vm_re      = 1'b1;
                vm_raddr   = i_reg + NW'(1);
                pm_re      = 1'b1;
                pm_raddr   = b_pidx;
                wait_next  = 1'b0;
                state_next = S_BM1;
            end
            S_BM1, S_BM2, S_BM3:
            begin
                case (state_reg)
                    S_BM1:
                    begin
                        mul_a = vm_q;
                        mul_b = p_reg;
                    end
                    S_BM2:
                    begin
                        mul_a = lo_reg;
                        mul_b = ONE_Q32 - p_reg;
                    end
                    default:
                    begin
                        mul_a = c1_reg;
                        mul_b = disc_reg;
                    end
                endcase
                if (!wait_reg)
                begin
                    mul_go    = 1'b1;
                    wait_next = 1'b1;
                end
                else if (mul_done)
                begin
                    wait_next = 1'b0;
                    if (state_reg == S_BM1)
                    begin
                        c1_next    = mul_satv;
                        state_next = S_BM2;
                    end
                    else if (state_reg == S_BM2)
                    begin
                        c1_next    = add_sat(c1_reg, mul_satv);
                        state_next = S_BM3;
                    end
                    else
                    begin
                        vm_we    = 1'b1;
                        vm_waddr = i_reg;
                        vm_wdata = (cont > exer) ? cont : exer;
                        lo_next  = vm_q;
                        if (i_reg == t_reg)
                        begin
                            if (t_reg == '0)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                t_next     = t_reg - NW'(1);
                                state_next = S_BINIT;
                            end
                        end
                        else
                        begin
                            i_next     = i_reg + NW'(1);
                            state_next = S_BRD;
                        end
                    end
                end
            end
            S_FIN:
            begin
                vm_re      = 1'b1;
                vm_raddr   = '0;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                price_next = (vm_q[63:48] != 16'd0) ? 32'hFFFF_FFFF : vm_q[47:16];
                valid_next = 1'b1;
                state_next = S_IDLE;
            end
            S_E0:
            begin
                mul_a = ex_mag;
                mul_b = LOG2E_Q32;
                if (!wait_reg)
                begin
                    if (ex_m_reg == 64'd0)
                    begin
                        ex_res_next = '0;
                        state_next  = ret_reg;
                    end
                    else if (ex_mag > EXP_LIMIT)
                    begin
                        ex_res_next = ex_x_reg[63] ? 64'd0 : MAX_U64;
                        state_next  = ret_reg;
                    end
                    else
                    begin
                        mul_go    = 1'b1;
                        wait_next = 1'b1;
                    end
                end
                else if (mul_done)
                begin
                    wait_next   = 1'b0;
                    ex_neg_next = ex_x_reg[63];
                    if (ex_x_reg[63] && mul_prod[63:32] != 32'd0)
                    begin
                        ex_e_next = mul_prod[71:64] + 8'd1;
                        ex_f_next = 32'd0 - mul_prod[63:32];
                    end
                    else
                    begin
                        ex_e_next = mul_prod[71:64];
                        ex_f_next = mul_prod[63:32];
                    end
                    state_next = S_EY;
                end
            end
            S_EY:
            begin
                mul_a = {32'b0, ex_f_reg};
                mul_b = LN2_Q32;
                if (!wait_reg)
                begin
                    mul_go    = 1'b1;
                    wait_next = 1'b1;
                end
                else if (mul_done)
                begin
                    wait_next    = 1'b0;
                    ex_z_next    = mul_prod[63:32];
                    ex_sum_next  = ONE_Q32;
                    ex_term_next = ONE_Q32;
                    ex_k_next    = 4'd1;
                    state_next   = S_ETM;
                end
            end
            S_ETM:
            begin
                mul_a = ex_term_reg;
                mul_b = {32'b0, ex_z_reg};
                if (!wait_reg)
                begin
                    mul_go    = 1'b1;
                    wait_next = 1'b1;
                end
                else if (mul_done)
                begin
                    wait_next  = 1'b0;
                    tmp_next   = mul_prod[95:32];
                    state_next = S_ETD;
                end
            end
            S_ETD:
            begin
                div_num   = tmp_reg;
                div_den   = DW'(ex_k_reg);
                div_short = 1'b1;
                if (!wait_reg)
                begin
                    div_go    = 1'b1;
                    wait_next = 1'b1;
                end
                else if (div_done)
                begin
                    wait_next    = 1'b0;
                    ex_term_next = div_quo;
                    ex_sum_next  = ex_sum_reg + div_quo;
                    if (ex_k_reg == TAYLOR_TERMS)
                    begin
                        state_next = S_EPR;
                    end
                    else
                    begin
                        ex_k_next  = ex_k_reg + 4'd1;
                        state_next = S_ETM;
                    end
                end
            end
            S_EPR:
            begin
                mul_a = ex_m_reg;
                mul_b = ex_sum_reg;
                if (!wait_reg)
                begin
                    mul_go    = 1'b1;
                    wait_next = 1'b1;
                end
                else if (mul_done)
                begin
                    wait_next   = 1'b0;
                    ex_res_next = ex_shift;
                    state_next  = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            wait_reg      <= 1'b0;
            valid_reg     <= 1'b0;
            num_steps_reg <= DEFAULT_STEPS;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            wait_reg  <= wait_next;
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                num_steps_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg    <= price_next;
        put_reg      <= put_next;
        spot_reg     <= spot_next;
        strike_reg   <= strike_next;
        expiry_reg   <= expiry_next;
        rate_reg     <= rate_next;
        divy_reg     <= divy_next;
        vol_reg      <= vol_next;
        n_reg        <= n_next;
        i_reg        <= i_next;
        t_reg        <= t_next;
        j_reg        <= j_next;
        sk_reg       <= sk_next;
        cnt_reg      <= cnt_next;
        root_x_reg   <= root_x_next;
        root_res_reg <= root_res_next;
        root_bit_reg <= root_bit_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        quo_reg      <= quo_next;
        a_reg        <= a_next;
        tmp_reg      <= tmp_next;
        rdt_reg      <= rdt_next;
        gdt_reg      <= gdt_next;
        disc_reg     <= disc_next;
        growth_reg   <= growth_next;
        up_reg       <= up_next;
        dn_reg       <= dn_next;
        p_reg        <= p_next;
        x_reg        <= x_next;
        lo_reg       <= lo_next;
        c1_reg       <= c1_next;
        ex_m_reg     <= ex_m_next;
        ex_x_reg     <= ex_x_next;
        ex_neg_reg   <= ex_neg_next;
        ex_e_reg     <= ex_e_next;
        ex_f_reg     <= ex_f_next;
        ex_z_reg     <= ex_z_next;
        ex_sum_reg   <= ex_sum_next;
        ex_term_reg  <= ex_term_next;
        ex_k_reg     <= ex_k_next;
        ex_res_reg   <= ex_res_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign price       = price_reg;
    assign price_valid = valid_reg;

`ifndef SYNTH
    a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        price_valid |-> !busy)
        else $error("price strobe while busy");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    a_unit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_done && div_done))
        else $error("multiplier and divider finished together");

    a_steps_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (n_reg >= NW'(1) && 32'(n_reg) <= 32'(MAX_STEPS)))
        else $error("step count out of range");

    a_level_order: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && (state_reg == S_BRD)) |-> (i_reg <= t_reg && t_reg < n_reg))
        else $error("node index beyond tree level");
`endif

endmodule
